>>> rtl/isiu_pkg.sv
// Shared constants, codes and state type for the interval set insert/union core.
`default_nettype none
package isiu_pkg;

    localparam int MAX_INTERVALS = 16;
    localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

    localparam int BOUND_W = 11;
    localparam int COUNT_OUT_W = 5;
    localparam int ENTRY_W = 2 * BOUND_W;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BEYOND = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_WAIT,
        S_SCAN_RD,
        S_SCAN_EV,
        S_PLAN,
        S_SHR_RD,
        S_SHR_WR,
        S_SHL_RD,
        S_SHL_WR,
        S_PUT,
        S_RESULT
    } state_t;

endpackage
`default_nettype wire

>>> rtl/interval_set_insert_union_core.sv
// Top level: sorted disjoint interval table with insert/union, read and clear.
// Usage:
//   Input transfers arrive on s_*: s_tuser carries the operation (insert, read,
//   clear, no-op), s_tdata the bounds and the entry position. Each input
//   transfer yields exactly one result transfer on m_*: merged or read bounds,
//   the interval count after the item, and a status code in m_tuser.
// Sequencing:
//   One item at a time; s_tready is high only while the sequencer is idle.
//   An insert scans the table from the bottom one entry at a time, then shifts
//   the entries above one at a time to open a slot or close the gap, and then
//   writes the merged interval; the entries scanned plus those shifted never
//   exceed the count plus one. An insert dropped on a full table only scans; a
//   read waits for the registered table read; clear, no-op and other rejects go
//   straight to the result. s_tready rises with m_tvalid.
// Reset:
//   aresetn low (synchronous) empties the table and drops any pending result.
//   Table contents are not cleared; only entries below the count are read.
// Stall:
//   The result sits in an output register; the next item is taken while it
//   waits, but the sequencer holds its own finished result until m_tready.
`default_nettype none
module interval_set_insert_union_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,   // range_low[10:0], range_high[21:11], entry_index[25:22]
    input  wire  [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // result_low[10:0], result_high[21:11], interval_count[26:22]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int BW = isiu_pkg::BOUND_W;
    localparam int CW = isiu_pkg::CNT_W;
    localparam int IW = isiu_pkg::IDX_W;
    localparam int EW = isiu_pkg::ENTRY_W;

    isiu_pkg::state_t state_reg, state_next;

    logic [BW-1:0] nlo_reg, nlo_next, nhi_reg, nhi_next;
    logic [BW-1:0] res_lo_reg, res_lo_next, res_hi_reg, res_hi_next;
    logic [1:0]    res_st_reg, res_st_next;
    logic [CW-1:0] i_reg, i_next, first_reg, first_next, k_reg, k_next;
    logic [CW-1:0] count_reg, count_next;
    logic          found_reg, found_next;

    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_data_reg, m_data_next;
    logic [1:0]    m_user_reg, m_user_next;

    // table storage, one write and one registered read a cycle
    logic [EW-1:0] mem [isiu_pkg::MAX_INTERVALS];
    logic [EW-1:0] rdata_reg;
    logic          mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    logic [BW-1:0] in_lo, in_hi, e_lo, e_hi;
    logic [3:0]    in_idx;
    logic [CW-1:0] merged;
    logic          e_before, e_touch;

    assign in_lo  = s_tdata[10:0];
    assign in_hi  = s_tdata[21:11];
    assign in_idx = s_tdata[25:22];
    assign e_lo   = rdata_reg[BW-1:0];
    assign e_hi   = rdata_reg[EW-1:BW];
    assign merged = i_reg - first_reg;

    // entry lies wholly below the new interval with a gap
    assign e_before = ({1'b0, e_hi} + 12'd1) < {1'b0, nlo_reg};
    // entry overlaps or abuts the growing union on its upper side
    assign e_touch  = {1'b0, e_lo} <= ({1'b0, nhi_reg} + 12'd1);

    assign s_tready = (state_reg == isiu_pkg::S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= isiu_pkg::S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        nlo_reg    <= nlo_next;
        nhi_reg    <= nhi_next;
        res_lo_reg <= res_lo_next;
        res_hi_reg <= res_hi_next;
        res_st_reg <= res_st_next;
        i_reg      <= i_next;
        first_reg  <= first_next;
        k_reg      <= k_next;
        found_reg  <= found_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    always_comb begin
        state_next   = state_reg;
        nlo_next     = nlo_reg;
        nhi_next     = nhi_reg;
        res_lo_next  = res_lo_reg;
        res_hi_next  = res_hi_reg;
        res_st_next  = res_st_reg;
        i_next       = i_reg;
        first_next   = first_reg;
        k_next       = k_reg;
        found_next   = found_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        mem_we       = 1'b0;
        mem_waddr    = k_reg[IW-1:0];
        mem_wdata    = rdata_reg;
        mem_raddr    = i_reg[IW-1:0];

        case (state_reg)
            isiu_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    res_lo_next = '0;
                    res_hi_next = '0;
                    res_st_next = isiu_pkg::ST_OK;
                    state_next  = isiu_pkg::S_RESULT;
                    case (s_tuser)
                        isiu_pkg::OP_INSERT: begin
                            if (in_lo > in_hi) begin
                                res_st_next = isiu_pkg::ST_EMPTY;
                            end else begin
                                nlo_next   = in_lo;
                                nhi_next   = in_hi;
                                i_next     = '0;
                                found_next = 1'b0;
                                state_next = isiu_pkg::S_SCAN_RD;
                            end
                        end
                        isiu_pkg::OP_READ: begin
                            if ((32'(in_idx) < 32'(count_reg)) &&
                                (32'(in_idx) < isiu_pkg::MAX_INTERVALS)) begin
                                mem_raddr  = IW'(in_idx);
                                state_next = isiu_pkg::S_RD_WAIT;
                            end else begin
                                res_st_next = isiu_pkg::ST_BEYOND;
                            end
                        end
                        isiu_pkg::OP_CLEAR: begin
                            count_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            isiu_pkg::S_RD_WAIT: begin
                res_lo_next = e_lo;
                res_hi_next = e_hi;
                state_next  = isiu_pkg::S_RESULT;
            end

            isiu_pkg::S_SCAN_RD: begin
                if (i_reg == count_reg) begin
                    if (!found_reg) begin
                        first_next = i_reg;
                    end
                    state_next = isiu_pkg::S_PLAN;
                end else begin
                    mem_raddr  = i_reg[IW-1:0];
                    state_next = isiu_pkg::S_SCAN_EV;
                end
            end

            isiu_pkg::S_SCAN_EV: begin
                if (!found_reg && e_before) begin
                    i_next     = i_reg + 1'b1;
                    state_next = isiu_pkg::S_SCAN_RD;
                end else begin
                    if (!found_reg) begin
                        first_next = i_reg;
                        found_next = 1'b1;
                    end
                    if (e_touch) begin
                        if (e_lo < nlo_reg) nlo_next = e_lo;
                        if (e_hi > nhi_reg) nhi_next = e_hi;
                        i_next     = i_reg + 1'b1;
                        state_next = isiu_pkg::S_SCAN_RD;
                    end else begin
                        state_next = isiu_pkg::S_PLAN;
                    end
                end
            end

            isiu_pkg::S_PLAN: begin
                if (merged == '0) begin
                    if (32'(count_reg) >= isiu_pkg::MAX_INTERVALS) begin
                        res_lo_next = '0;
                        res_hi_next = '0;
                        res_st_next = isiu_pkg::ST_FULL;
                        state_next  = isiu_pkg::S_RESULT;
                    end else begin
                        k_next     = count_reg;
                        state_next = isiu_pkg::S_SHR_RD;
                    end
                end else begin
                    k_next     = i_reg;
                    state_next = isiu_pkg::S_SHL_RD;
                end
            end

            // open a slot at first: move entries up, top one first
            isiu_pkg::S_SHR_RD: begin
                if (k_reg == first_reg) begin
                    state_next = isiu_pkg::S_PUT;
                end else begin
                    mem_raddr  = IW'(k_reg - 1'b1);
                    state_next = isiu_pkg::S_SHR_WR;
                end
            end

            isiu_pkg::S_SHR_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = k_reg[IW-1:0];
                k_next     = k_reg - 1'b1;
                state_next = isiu_pkg::S_SHR_RD;
            end

            // close the gap left by the folded entries
            isiu_pkg::S_SHL_RD: begin
                if (k_reg == count_reg) begin
                    state_next = isiu_pkg::S_PUT;
                end else begin
                    mem_raddr  = k_reg[IW-1:0];
                    state_next = isiu_pkg::S_SHL_WR;
                end
            end

            isiu_pkg::S_SHL_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = IW'(k_reg - merged + 1'b1);
                k_next     = k_reg + 1'b1;
                state_next = isiu_pkg::S_SHL_RD;
            end

            isiu_pkg::S_PUT: begin
                mem_we      = 1'b1;
                mem_waddr   = first_reg[IW-1:0];
                mem_wdata   = {nhi_reg, nlo_reg};
                count_next  = count_reg - merged + 1'b1;
                res_lo_next = nlo_reg;
                res_hi_next = nhi_reg;
                res_st_next = isiu_pkg::ST_OK;
                state_next  = isiu_pkg::S_RESULT;
            end

            isiu_pkg::S_RESULT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'd0, isiu_pkg::COUNT_OUT_W'(count_reg),
                                    res_hi_reg, res_lo_reg};
                    m_user_next  = res_st_reg;
                    state_next   = isiu_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = isiu_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/isiu_checker.sv
// Port-level checks for the interval set core, bound to the top level.
`default_nettype none
module isiu_port_checks (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire [1:0]  m_tuser
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one item in flight: no back-to-back input transfers
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(m_tdata[26:22]) <= isiu_pkg::MAX_INTERVALS))
        else $error("interval count beyond capacity");

    // rejected items carry zero bounds
    a_zero_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != isiu_pkg::ST_OK) |-> (m_tdata[21:0] == 22'd0))
        else $error("non-zero bounds on rejected item");

    a_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == isiu_pkg::ST_OK) |-> (m_tdata[10:0] <= m_tdata[21:11]))
        else $error("result low above high");

endmodule

bind interval_set_insert_union_core isiu_port_checks u_isiu_port_checks (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

>>> tb/sv/isiu_checker.sv
// Channel monitor for the interval set core: predicts each result and compares it.
`timescale 1ns / 1ps
module isiu_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [31:0] s_tdata,   // range_low[10:0], range_high[21:11], entry_index[25:22]
    input  wire  [1:0]  s_tuser,   // operation[1:0]
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [31:0] m_tdata,   // result_low[10:0], result_high[21:11], interval_count[26:22]
    input  wire  [1:0]  m_tuser,   // status[1:0]
    output int          fail_count,
    output int          pending,
    output int          checked
);

    typedef struct packed {
        logic [isiu_pkg::BOUND_W-1:0]     lo;
        logic [isiu_pkg::BOUND_W-1:0]     hi;
        logic [isiu_pkg::COUNT_OUT_W-1:0] count;
        logic [1:0]                       status;
    } span_result_t;

    // mirror of the interval table, kept sorted and disjoint
    int span_lo [isiu_pkg::MAX_INTERVALS];
    int span_hi [isiu_pkg::MAX_INTERVALS];
    int span_count;
    span_result_t awaited_results [$];

    initial begin
        fail_count = 0;
        pending    = 0;
        checked    = 0;
        span_count = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // applies one item to the mirror and returns the result it should produce
    function automatic span_result_t fold_item(input logic [1:0] op, input int lo, input int hi,
                                               input int idx);
        span_result_t r;
        int first;
        int last;
        int merged;
        int nlo;
        int nhi;
        int k;
        r = '0;
        case (op)
            isiu_pkg::OP_INSERT: begin
                if (lo > hi) begin
                    r.status = isiu_pkg::ST_EMPTY;
                end else begin
                    first = 0;
                    while (first < span_count && span_hi[first] + 1 < lo) first++;
                    // fold everything that overlaps or touches with no gap
                    last = first;
                    nlo  = lo;
                    nhi  = hi;
                    while (last < span_count && span_lo[last] <= nhi + 1) begin
                        if (span_lo[last] < nlo) nlo = span_lo[last];
                        if (span_hi[last] > nhi) nhi = span_hi[last];
                        last++;
                    end
                    merged = last - first;
                    if (merged == 0 && span_count >= isiu_pkg::MAX_INTERVALS) begin
                        r.status = isiu_pkg::ST_FULL;
                    end else begin
                        if (merged == 0) begin
                            for (k = span_count; k > first; k--) begin
                                span_lo[k] = span_lo[k-1];
                                span_hi[k] = span_hi[k-1];
                            end
                            span_count++;
                        end else begin
                            for (k = last; k < span_count; k++) begin
                                span_lo[k-merged+1] = span_lo[k];
                                span_hi[k-merged+1] = span_hi[k];
                            end
                            span_count = span_count - merged + 1;
                        end
                        span_lo[first] = nlo;
                        span_hi[first] = nhi;
                        r.lo     = nlo[isiu_pkg::BOUND_W-1:0];
                        r.hi     = nhi[isiu_pkg::BOUND_W-1:0];
                        r.status = isiu_pkg::ST_OK;
                    end
                end
            end
            isiu_pkg::OP_READ: begin
                if (idx < span_count) begin
                    r.lo = span_lo[idx][isiu_pkg::BOUND_W-1:0];
                    r.hi = span_hi[idx][isiu_pkg::BOUND_W-1:0];
                end else begin
                    r.status = isiu_pkg::ST_BEYOND;
                end
            end
            isiu_pkg::OP_CLEAR: begin
                span_count = 0;
            end
            default: begin
            end
        endcase
        r.count = span_count[isiu_pkg::COUNT_OUT_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        span_result_t want;
        if (!aresetn) begin
            span_count = 0;
            awaited_results.delete();
        end else begin
            // results first: one accepted at this edge belongs to an earlier item
            if (m_tvalid && m_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result transfer with nothing awaited, tdata", m_tdata, 0);
                end else begin
                    want = awaited_results.pop_front();
                    checked++;
                    if (m_tdata[10:0] !== want.lo)
                        report_mismatch("result_low", m_tdata[10:0], want.lo);
                    if (m_tdata[21:11] !== want.hi)
                        report_mismatch("result_high", m_tdata[21:11], want.hi);
                    if (m_tdata[26:22] !== want.count)
                        report_mismatch("interval_count", m_tdata[26:22], want.count);
                    if (m_tdata[31:27] !== 5'd0)
                        report_mismatch("tdata padding", m_tdata[31:27], 0);
                    if (m_tuser !== want.status)
                        report_mismatch("status", m_tuser, want.status);
                end
            end
            if (s_tvalid && s_tready)
                awaited_results.insert(awaited_results.size(),
                                       fold_item(s_tuser, s_tdata[10:0], s_tdata[21:11],
                                                 s_tdata[25:22]));
        end
        pending = awaited_results.size();
    end

endmodule

>>> tb/sv/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the interval set core.
`timescale 1ns / 1ps
module tb_top;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int ITEMS_PER_PHASE = 425;
    localparam int DRAIN_LIMIT     = 20000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = 32'd0;   // range_low[10:0], range_high[21:11], entry_index[25:22]
    logic [1:0]  s_tuser  = 2'd0;    // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;            // result_low[10:0], result_high[21:11], interval_count[26:22]
    logic [1:0]  m_tuser;            // status[1:0]

    int fail_count;
    int pending;
    int checked;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent_by_op [4];

    always #5 aclk = ~aclk;

    interval_set_insert_union_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    isiu_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one input transfer, preceded by a random idle gap on the sender side
    task automatic send_item(input logic [1:0] op, input int lo, input int hi, input int idx);
        int gap;
        logic took;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 2'($urandom_range(3));
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, idx[3:0], hi[10:0], lo[10:0]};
        // tready is settled by the falling edge and holds until the next rising one
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        sent_by_op[op]++;
    endtask

    task automatic send_random_item();
        int sel;
        int shape;
        int lo;
        int hi;
        sel = $urandom_range(99);
        if (sel < 2) begin
            send_item(isiu_pkg::OP_CLEAR, $urandom_range(2047), $urandom_range(2047),
                      $urandom_range(15));
        end else if (sel < 5) begin
            send_item(OP_NOP, $urandom_range(2047), $urandom_range(2047), $urandom_range(15));
        end else if (sel < 33) begin
            send_item(isiu_pkg::OP_READ, $urandom_range(2047), $urandom_range(2047),
                      $urandom_range(15));
        end else begin
            shape = $urandom_range(99);
            if (shape < 8) begin
                lo = $urandom_range(2047);
                hi = $urandom_range(2047);
            end else if (shape < 12) begin
                // wide span, folds many entries at once
                lo = $urandom_range(1023);
                hi = lo + $urandom_range(256, 1024);
            end else if (shape < 16) begin
                hi = $urandom_range(2046);
                lo = hi + 1 + $urandom_range(40);
            end else begin
                // coarse grid so that neighbours often touch or overlap
                lo = 32 * $urandom_range(63) + $urandom_range(3);
                hi = lo + $urandom_range(34);
            end
            if (lo > 2047) lo = 2047;
            if (hi > 2047) hi = 2047;
            send_item(isiu_pkg::OP_INSERT, lo, hi, $urandom_range(15));
        end
    endtask

    initial begin : stimulus
        int k;
        int slot;
        int waited;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part: empty table, bounds at the extremes, full table, total fold
        send_item(isiu_pkg::OP_CLEAR, 0, 0, 0);
        send_item(isiu_pkg::OP_READ, 0, 0, 0);
        send_item(isiu_pkg::OP_INSERT, 2047, 0, 0);
        send_item(OP_NOP, 2047, 2047, 15);
        for (k = 0; k < isiu_pkg::MAX_INTERVALS; k++) begin
            slot = (k * 7) % isiu_pkg::MAX_INTERVALS;
            if (slot == isiu_pkg::MAX_INTERVALS - 1)
                send_item(isiu_pkg::OP_INSERT, slot * 128, 2047, 0);
            else
                send_item(isiu_pkg::OP_INSERT, slot * 128, slot * 128 + 1, 0);
        end
        send_item(isiu_pkg::OP_INSERT, 1000, 1000, 0);
        send_item(isiu_pkg::OP_INSERT, 2, 2, 0);
        send_item(isiu_pkg::OP_READ, 0, 0, 15);
        send_item(isiu_pkg::OP_INSERT, 0, 2047, 0);
        send_item(isiu_pkg::OP_READ, 2047, 2047, 1);

        // random part over the handshake phases
        for (k = 0; k < 4; k++) begin
            case (k)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 66;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 66;
                end
                default: begin
                    send_idle_pct  = 34;
                    recv_stall_pct = 34;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_random_item();
        end
        s_tvalid <= 1'b0;

        waited = 0;
        @(negedge aclk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (pending != 0) begin
            $display("timeout: %0d results still outstanding", pending);
            $display("Verification failed");
            $finish;
        end else begin
            repeat (4 * isiu_pkg::MAX_INTERVALS + 8) @(negedge aclk);
            $display("Drove %0d inserts, %0d reads, %0d clears and %0d no-ops",
                     sent_by_op[isiu_pkg::OP_INSERT], sent_by_op[isiu_pkg::OP_READ],
                     sent_by_op[isiu_pkg::OP_CLEAR], sent_by_op[OP_NOP]);
            $display("%0d results compared over four idle/stall phases, %0d mismatches",
                     checked, fail_count);
            if (fail_count == 0 && pending == 0) begin
                $display("Verification passed");
            end else begin
                if (pending != 0) $display("%0d results never arrived", pending);
                $display("Verification failed");
            end
            $finish;
        end
    end

    initial begin : watchdog
        #20_000_000;
        $display("watchdog expired");
        $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/isiu_pkg.sv
rtl/interval_set_insert_union_core.sv
rtl/isiu_checker.sv
tb/sv/isiu_checker.sv
tb/sv/tb_top.sv
